[sv/tvs_pkg.sv]
`default_nettype none
package tvs_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int SAMPLE_BITS = 16;

  localparam int COORD_W  = 16;
  localparam int CORNER_W = 16;
  localparam int OUT_W    = 40;

  localparam int LOW_LIMIT  = 1;
  localparam int HIGH_LIMIT = 254;

  // weight runs 0 .. 2^FRAC_BITS inclusive
  localparam int WGT_W = FRAC_BITS + 1;
  // exact widths after each lerp pass
  localparam int XW = SAMPLE_BITS + FRAC_BITS;
  localparam int YW = XW + FRAC_BITS;
  localparam int ZW = YW + FRAC_BITS;
  // headroom for the clamp compare
  localparam int EXT_W = (ZW > OUT_W) ? ZW : OUT_W + 1;

  localparam logic [COORD_W-1:0] COORD_LO = COORD_W'(LOW_LIMIT << FRAC_BITS);
  localparam logic [COORD_W-1:0] COORD_HI = COORD_W'(HIGH_LIMIT << FRAC_BITS);
  localparam logic [WGT_W-1:0]   WGT_ONE  = WGT_W'(1 << FRAC_BITS);

  localparam logic signed [EXT_W-1:0] SAT_MAX = EXT_W'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [EXT_W-1:0] SAT_MIN = ~SAT_MAX;

  typedef logic [WGT_W-1:0] weight_t;

  typedef struct packed {
    weight_t w0;
    weight_t w1;
  } weight_pair_t;

  typedef struct packed {
    logic vld;
    logic in_win;
  } tvs_ctl_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [XW-1:0] xval_t;
  typedef logic signed [YW-1:0] yval_t;
  typedef logic signed [ZW-1:0] zval_t;

  function automatic weight_pair_t make_weights(input logic [COORD_W-1:0] c);
    weight_pair_t p;
    p.w1 = WGT_W'(c[FRAC_BITS-1:0]);
    p.w0 = WGT_ONE - p.w1;
    return p;
  endfunction

  function automatic logic coord_ok(input logic [COORD_W-1:0] c);
    return (c >= COORD_LO) && (c <= COORD_HI);
  endfunction

  function automatic xval_t lerp_x(input sample_t a, input sample_t b,
                                   input weight_pair_t w);
    logic signed [XW+1:0] pa;
    logic signed [XW+1:0] pb;
    logic signed [XW+1:0] s;
    pa = (XW+2)'(a) * (XW+2)'($signed({1'b0, w.w0}));
    pb = (XW+2)'(b) * (XW+2)'($signed({1'b0, w.w1}));
    s  = pa + pb;
    return s[XW-1:0];
  endfunction

  function automatic yval_t lerp_y(input xval_t a, input xval_t b,
                                   input weight_pair_t w);
    logic signed [YW+1:0] pa;
    logic signed [YW+1:0] pb;
    logic signed [YW+1:0] s;
    pa = (YW+2)'(a) * (YW+2)'($signed({1'b0, w.w0}));
    pb = (YW+2)'(b) * (YW+2)'($signed({1'b0, w.w1}));
    s  = pa + pb;
    return s[YW-1:0];
  endfunction

  function automatic zval_t lerp_z(input yval_t a, input yval_t b,
                                   input weight_pair_t w);
    logic signed [ZW+1:0] pa;
    logic signed [ZW+1:0] pb;
    logic signed [ZW+1:0] s;
    pa = (ZW+2)'(a) * (ZW+2)'($signed({1'b0, w.w0}));
    pb = (ZW+2)'(b) * (ZW+2)'($signed({1'b0, w.w1}));
    s  = pa + pb;
    return s[ZW-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/tvs_front.sv]
`default_nettype none
module tvs_front (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  en,
  input  wire logic                                  in_vld,
  input  wire logic [tvs_pkg::COORD_W-1:0]           x_coord,
  input  wire logic [tvs_pkg::COORD_W-1:0]           y_coord,
  input  wire logic [tvs_pkg::COORD_W-1:0]           z_coord,
  input  wire tvs_pkg::sample_t                      corners [8],
  output tvs_pkg::tvs_ctl_t                          ctl,
  output tvs_pkg::xval_t                             xl [4],
  output tvs_pkg::weight_pair_t                      wy,
  output tvs_pkg::weight_pair_t                      wz
);

  tvs_pkg::weight_pair_t wx_c;
  tvs_pkg::xval_t        xl_next [4];

  assign wx_c = tvs_pkg::make_weights(x_coord);

  // lane j blends the x pair at y = j[0], z = j[1]
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      xl_next[j] = tvs_pkg::lerp_x(corners[2*j], corners[2*j+1], wx_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl.vld <= in_vld;
    end
    if (en) begin
      ctl.in_win <= tvs_pkg::coord_ok(x_coord) && tvs_pkg::coord_ok(y_coord) &&
                    tvs_pkg::coord_ok(z_coord);
      xl         <= xl_next;
      wy         <= tvs_pkg::make_weights(y_coord);
      wz         <= tvs_pkg::make_weights(z_coord);
    end
  end

endmodule
`default_nettype wire

[sv/tvs_ylerp.sv]
`default_nettype none
module tvs_ylerp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire tvs_pkg::tvs_ctl_t       ctl_in,
  input  wire tvs_pkg::xval_t          xl [4],
  input  wire tvs_pkg::weight_pair_t   wy,
  input  wire tvs_pkg::weight_pair_t   wz_in,
  output tvs_pkg::tvs_ctl_t            ctl,
  output tvs_pkg::yval_t               yl [2],
  output tvs_pkg::weight_pair_t        wz
);

  tvs_pkg::yval_t yl_next [2];

  always_comb begin
    for (int m = 0; m < 2; m++) begin
      yl_next[m] = tvs_pkg::lerp_y(xl[2*m], xl[2*m+1], wy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl.vld <= ctl_in.vld;
    end
    if (en) begin
      ctl.in_win <= ctl_in.in_win;
      yl         <= yl_next;
      wz         <= wz_in;
    end
  end

endmodule
`default_nettype wire

[sv/tvs_zlerp.sv]
`default_nettype none
module tvs_zlerp (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire tvs_pkg::tvs_ctl_t       ctl_in,
  input  wire tvs_pkg::yval_t          yl [2],
  input  wire tvs_pkg::weight_pair_t   wz,
  output tvs_pkg::tvs_ctl_t            ctl,
  output tvs_pkg::zval_t               zl
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.vld <= 1'b0;
    end else if (en) begin
      ctl.vld <= ctl_in.vld;
    end
    if (en) begin
      ctl.in_win <= ctl_in.in_win;
      zl         <= tvs_pkg::lerp_z(yl[0], yl[1], wz);
    end
  end

endmodule
`default_nettype wire

[sv/trilinear_voxel_sampler_top.sv]
`default_nettype none
// Trilinear sampler: takes three unsigned 8.8 coordinates and the eight signed corner voxels of
// the enclosing cell and returns their exact trilinear blend as a signed value with 24
// fractional bits; a coordinate below 1.0 or above 254.0 gives zero. The datapath is a
// four-stage pipeline (x lerp, y lerp, z lerp, window/clamp and output register), and one
// transaction can be accepted every cycle while out_ready does not stall it. Backpressure on
// out_ready stalls the whole pipeline; bubbles in it are filled, so in_ready stays high while
// any stage is empty.
module trilinear_voxel_sampler_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [tvs_pkg::COORD_W-1:0]       x_coord,
  input  wire logic [tvs_pkg::COORD_W-1:0]       y_coord,
  input  wire logic [tvs_pkg::COORD_W-1:0]       z_coord,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_000,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_100,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_010,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_110,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_001,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_101,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_011,
  input  wire logic signed [tvs_pkg::CORNER_W-1:0] corner_111,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed [tvs_pkg::OUT_W-1:0]       sample_value
);

  tvs_pkg::sample_t      corners [8];
  tvs_pkg::tvs_ctl_t     ctl1;
  tvs_pkg::tvs_ctl_t     ctl2;
  tvs_pkg::tvs_ctl_t     ctl3;
  tvs_pkg::xval_t        xl [4];
  tvs_pkg::yval_t        yl [2];
  tvs_pkg::zval_t        zl;
  tvs_pkg::weight_pair_t wy1;
  tvs_pkg::weight_pair_t wz1;
  tvs_pkg::weight_pair_t wz2;
  logic                  en1;
  logic                  en2;
  logic                  en3;
  logic                  en4;
  logic signed [tvs_pkg::EXT_W-1:0] zext;
  logic signed [tvs_pkg::OUT_W-1:0] sample_next;

  // corner value is the low SAMPLE_BITS of its field
  assign corners[0] = corner_000[tvs_pkg::SAMPLE_BITS-1:0];
  assign corners[1] = corner_100[tvs_pkg::SAMPLE_BITS-1:0];
  assign corners[2] = corner_010[tvs_pkg::SAMPLE_BITS-1:0];
  assign corners[3] = corner_110[tvs_pkg::SAMPLE_BITS-1:0];
  assign corners[4] = corner_001[tvs_pkg::SAMPLE_BITS-1:0];
  assign corners[5] = corner_101[tvs_pkg::SAMPLE_BITS-1:0];
  assign corners[6] = corner_011[tvs_pkg::SAMPLE_BITS-1:0];
  assign corners[7] = corner_111[tvs_pkg::SAMPLE_BITS-1:0];

  // a stage advances when it is empty or the one after it advances
  assign en4      = !out_valid || out_ready;
  assign en3      = !ctl3.vld || en4;
  assign en2      = !ctl2.vld || en3;
  assign en1      = !ctl1.vld || en2;
  assign in_ready = en1;

  tvs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en1),
    .in_vld  (in_valid),
    .x_coord (x_coord),
    .y_coord (y_coord),
    .z_coord (z_coord),
    .corners (corners),
    .ctl     (ctl1),
    .xl      (xl),
    .wy      (wy1),
    .wz      (wz1)
  );

  tvs_ylerp u_ylerp (
    .clk    (clk),
    .rst    (rst),
    .en     (en2),
    .ctl_in (ctl1),
    .xl     (xl),
    .wy     (wy1),
    .wz_in  (wz1),
    .ctl    (ctl2),
    .yl     (yl),
    .wz     (wz2)
  );

  tvs_zlerp u_zlerp (
    .clk    (clk),
    .rst    (rst),
    .en     (en3),
    .ctl_in (ctl2),
    .yl     (yl),
    .wz     (wz2),
    .ctl    (ctl3),
    .zl     (zl)
  );

  assign zext = tvs_pkg::EXT_W'(zl);

  // zero outside the window, clamp to the output range otherwise
  always_comb begin
    priority if (!ctl3.in_win) begin
      sample_next = '0;
    end else if (zext > tvs_pkg::SAT_MAX) begin
      sample_next = tvs_pkg::SAT_MAX[tvs_pkg::OUT_W-1:0];
    end else if (zext < tvs_pkg::SAT_MIN) begin
      sample_next = tvs_pkg::SAT_MIN[tvs_pkg::OUT_W-1:0];
    end else begin
      sample_next = zext[tvs_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= ctl3.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      sample_value <= sample_next;
    end
  end

endmodule
`default_nettype wire

[tb/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_SAMPLES = 1932;
  localparam int CALM_SAMPLES   = 200;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  // window edges as raw coordinate codes
  localparam int WIN_LO = tvs_pkg::LOW_LIMIT << tvs_pkg::FRAC_BITS;
  localparam int WIN_HI = tvs_pkg::HIGH_LIMIT << tvs_pkg::FRAC_BITS;
  localparam logic [tvs_pkg::COORD_W-1:0] COORD_TOP = '1;
  localparam logic [tvs_pkg::CORNER_W-1:0] CORNER_MIN =
    {1'b1, {(tvs_pkg::CORNER_W-1){1'b0}}};
  localparam logic [tvs_pkg::CORNER_W-1:0] CORNER_MAX =
    {1'b0, {(tvs_pkg::CORNER_W-1){1'b1}}};

  // corner index: bit 0 is x, bit 1 is y, bit 2 is z
  typedef struct packed {
    logic [tvs_pkg::COORD_W-1:0]       x;
    logic [tvs_pkg::COORD_W-1:0]       y;
    logic [tvs_pkg::COORD_W-1:0]       z;
    logic [7:0][tvs_pkg::CORNER_W-1:0] corner;
  } sample_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  sample_req_t cur_req = '0;
  logic in_ready;
  logic out_valid;
  logic signed [tvs_pkg::OUT_W-1:0] sample_value;

  sample_req_t queued_samples[$];
  logic signed [tvs_pkg::OUT_W-1:0] blends_due[$];

  logic in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int idle_cycles = 0;
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_outside = 0;

  trilinear_voxel_sampler_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .x_coord      (cur_req.x),
    .y_coord      (cur_req.y),
    .z_coord      (cur_req.z),
    .corner_000   (cur_req.corner[0]),
    .corner_100   (cur_req.corner[1]),
    .corner_010   (cur_req.corner[2]),
    .corner_110   (cur_req.corner[3]),
    .corner_001   (cur_req.corner[4]),
    .corner_101   (cur_req.corner[5]),
    .corner_011   (cur_req.corner[6]),
    .corner_111   (cur_req.corner[7]),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit in_window(logic [tvs_pkg::COORD_W-1:0] c);
    return int'(c) >= WIN_LO && int'(c) <= WIN_HI;
  endfunction

  function automatic bit req_inside(sample_req_t r);
    return in_window(r.x) && in_window(r.y) && in_window(r.z);
  endfunction

  function automatic logic signed [tvs_pkg::OUT_W-1:0] trilinear_blend(sample_req_t r);
    longint one;
    longint wx[2];
    longint wy[2];
    longint wz[2];
    longint acc;
    longint sat_hi;
    longint sat_lo;
    logic [tvs_pkg::SAMPLE_BITS-1:0] raw;
    if (!req_inside(r)) return '0;
    one = longint'(1) <<< tvs_pkg::FRAC_BITS;
    wx[1] = longint'(r.x[tvs_pkg::FRAC_BITS-1:0]);
    wy[1] = longint'(r.y[tvs_pkg::FRAC_BITS-1:0]);
    wz[1] = longint'(r.z[tvs_pkg::FRAC_BITS-1:0]);
    wx[0] = one - wx[1];
    wy[0] = one - wy[1];
    wz[0] = one - wz[1];
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      // only the low SAMPLE_BITS of each corner are significant
      raw = r.corner[k][tvs_pkg::SAMPLE_BITS-1:0];
      acc += longint'($signed(raw)) * wx[k & 1] * wy[(k >> 1) & 1] * wz[(k >> 2) & 1];
    end
    sat_hi = (longint'(1) <<< (tvs_pkg::OUT_W - 1)) - 1;
    sat_lo = -sat_hi - 1;
    if (acc > sat_hi) acc = sat_hi;
    if (acc < sat_lo) acc = sat_lo;
    return acc[tvs_pkg::OUT_W-1:0];
  endfunction

  task automatic add_sample(input int x, input int y, input int z,
                            input logic [7:0][tvs_pkg::CORNER_W-1:0] c);
    sample_req_t r;
    r.x = tvs_pkg::COORD_W'(x);
    r.y = tvs_pkg::COORD_W'(y);
    r.z = tvs_pkg::COORD_W'(z);
    r.corner = c;
    queued_samples = {queued_samples, r};
  endtask

  function automatic logic [tvs_pkg::COORD_W-1:0] random_coord();
    logic [tvs_pkg::COORD_W-1:0] c;
    case ($urandom_range(0, 9))
      0: c = tvs_pkg::COORD_W'($urandom_range(0, int'(COORD_TOP)));
      1: begin
        case ($urandom_range(0, 3))
          0: c = tvs_pkg::COORD_W'(WIN_LO - 1);
          1: c = tvs_pkg::COORD_W'(WIN_LO);
          2: c = tvs_pkg::COORD_W'(WIN_HI);
          default: c = tvs_pkg::COORD_W'(WIN_HI + 1);
        endcase
      end
      default: begin
        c = tvs_pkg::COORD_W'($urandom_range(WIN_LO, WIN_HI));
        // push the fraction to all zeros or all ones now and then
        if ($urandom_range(0, 7) == 0)
          c[tvs_pkg::FRAC_BITS-1:0] = {tvs_pkg::FRAC_BITS{c[tvs_pkg::FRAC_BITS]}};
      end
    endcase
    return c;
  endfunction

  function automatic logic [tvs_pkg::CORNER_W-1:0] random_corner();
    case ($urandom_range(0, 7))
      0: return CORNER_MIN;
      1: return CORNER_MAX;
      2: return tvs_pkg::CORNER_W'($urandom_range(0, 15) - 8);
      default: return tvs_pkg::CORNER_W'($urandom);
    endcase
  endfunction

  function automatic sample_req_t random_sample();
    sample_req_t r;
    logic [tvs_pkg::CORNER_W-1:0] v;
    r.x = random_coord();
    r.y = random_coord();
    r.z = random_coord();
    if ($urandom_range(0, 15) == 0) begin
      v = $urandom_range(0, 1) ? CORNER_MAX : CORNER_MIN;
      r.corner = {8{v}};
    end else begin
      for (int k = 0; k < 8; k++) r.corner[k] = random_corner();
    end
    return r;
  endfunction

  // driver: present one transaction at a time, with random gaps
  always @(negedge clk) begin
    bit calm;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
      in_gap = 0;
      out_gap = 0;
    end else begin
      calm = queued_samples.size() < CALM_SAMPLES;
      // hold the current transaction until it is taken
      if (!(in_valid && !in_taken)) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (queued_samples.size() != 0 && !calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else if (queued_samples.size() != 0) begin
          cur_req <= queued_samples.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(0, 13);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what,
                                 input logic signed [tvs_pkg::OUT_W-1:0] want,
                                 input logic signed [tvs_pkg::OUT_W-1:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // monitor: check results in order, then record new transactions
  always @(posedge clk) begin
    logic signed [tvs_pkg::OUT_W-1:0] want;
    if (rst) begin
      in_taken <= 1'b0;
      idle_cycles = 0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (blends_due.size() == 0) begin
          report_mismatch("result with nothing pending", '0, sample_value);
        end else begin
          want = blends_due.pop_front();
          n_checked++;
          if (sample_value !== want) report_mismatch("sample_value", want, sample_value);
        end
      end
      if (in_valid && in_ready) begin
        blends_due = {blends_due, trilinear_blend(cur_req)};
        n_sent++;
        if (!req_inside(cur_req)) n_outside++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results pending",
                 idle_cycles, blends_due.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    // cells at and near both window edges, mostly with full-scale corner values
    add_sample(WIN_LO, WIN_LO, WIN_LO, {8{CORNER_MIN}});
    add_sample(WIN_HI, WIN_HI, WIN_HI, {8{CORNER_MAX}});
    add_sample(WIN_LO + 8'hFF, WIN_LO + 8'hFF, WIN_LO + 8'hFF, {8{CORNER_MIN}});
    add_sample(WIN_HI - 1, WIN_HI - 1, WIN_HI - 1,
               {CORNER_MAX, {7{16'h0000}}});
    add_sample(WIN_HI - 1, WIN_HI - 1, WIN_HI - 1,
               {CORNER_MIN, {7{CORNER_MAX}}});
    add_sample(16'h0180, 16'h0180, 16'h0180,
               {CORNER_MAX, CORNER_MIN, CORNER_MAX, CORNER_MIN,
                CORNER_MIN, CORNER_MAX, CORNER_MIN, CORNER_MAX});
    // each axis just outside the window on either side, then all axes at the code extremes
    add_sample(WIN_LO - 1, 16'h4080, 16'h4080, {8{CORNER_MAX}});
    add_sample(16'h4080, WIN_LO - 1, 16'h4080, {8{CORNER_MAX}});
    add_sample(16'h4080, 16'h4080, WIN_LO - 1, {8{CORNER_MAX}});
    add_sample(WIN_HI + 1, 16'h4080, 16'h4080, {8{CORNER_MIN}});
    add_sample(16'h4080, WIN_HI + 1, 16'h4080, {8{CORNER_MIN}});
    add_sample(16'h4080, 16'h4080, WIN_HI + 1, {8{CORNER_MIN}});
    add_sample(0, 0, 0, {8{CORNER_MAX}});
    add_sample(COORD_TOP, COORD_TOP, COORD_TOP, {8{CORNER_MIN}});
    // integer position puts all weight on the floor corner, then mixed positions
    add_sample(16'h4000, 16'h2100, 16'h7700,
               {{7{CORNER_MAX}}, 16'sd1234});
    add_sample(16'hAAAA, 16'h5555, 16'h1234,
               {{4{16'hAAAA}}, {4{16'h5555}}});
    add_sample(WIN_LO, WIN_HI, 16'h80FF,
               {16'h0001, 16'hFFFF, 16'h0100, 16'hFF00,
                16'h1000, 16'hF000, 16'h0010, 16'hFFF0});
    add_sample(16'h2233, 16'h4455, 16'h6677, {8{16'h0000}});
    for (int i = 0; i < RANDOM_SAMPLES; i++)
      queued_samples = {queued_samples, random_sample()};

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (queued_samples.size() != 0 || in_valid || blends_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (blends_due.size() != 0) begin
      $display("%0d results never arrived", blends_due.size());
      errors += blends_due.size();
    end

    $display("sent %0d samples, checked %0d blends (%0d outside the window),",
             n_sent, n_checked, n_outside);
    $display("with random stalls on both handshakes; %0d mismatches", errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tvs_pkg.sv
sv/tvs_front.sv
sv/tvs_ylerp.sv
sv/tvs_zlerp.sv
sv/trilinear_voxel_sampler_top.sv
tb/tb_top.sv
